FILE: hdl/lgfs_pkg.sv
`timescale 1ns / 1ps

package lgfs_pkg;

   localparam int BOARDS_DEFAULT     = 2;
   localparam int CHANNELS_PER_BOARD = 24;
   localparam int WORD_BITS          = 12;
   localparam int CHAN_BITS          = 6;
   localparam int LEVEL_BITS         = 16;

   localparam logic [WORD_BITS-1:0]  WORD_MAX  = 12'hFFF;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 16'h0FFF;

   localparam logic [1:0] ACTION_SET    = 2'd0;
   localparam logic [1:0] ACTION_READ   = 2'd1;
   localparam logic [1:0] ACTION_COMMIT = 2'd2;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef struct packed {
      logic [1:0]            action;
      logic [CHAN_BITS-1:0]  channel;
      logic [LEVEL_BITS-1:0] level;
   } req_type;

   typedef struct packed {
      logic                 kind;
      logic [WORD_BITS-1:0] word;
      logic                 bad_channel;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [CHAN_BITS-1:0] channel;
      logic [WORD_BITS-1:0] word;
   } wr_type;

endpackage

FILE: hdl/led_grayscale_frame_store_top.sv
`timescale 1ns / 1ps

// Grayscale frame store for a chain of BOARDS LED driver boards, 24 channels each.
// req_* channel (valid/ready) takes one word: set, read or commit.
// rsp_* channel (valid/ready) returns read replies and frame words.
// The store is a ring of one cell per channel; commit and read rotate the ring
// one full turn, which brings it back to rest alignment.
// Set: taken with no reply; the next word can follow at once.
// Read inside the chain: the ring turns once in ST_READ while the word is caught
// at the head, then ST_REPLY loads the reply into the output register; a channel
// outside the chain goes straight to ST_REPLY and replies with bad_channel set.
// Commit: one frame word per cycle while the receiver is not stalling, highest channel
// first, each through the output register, last set on channel 0; CHAIN_LEN words in all.
// req_ready is high only while no read or commit is in progress.
// A stalled receiver holds the output register and pauses the commit turn.
// Synchronous reset clears every cell to zero and empties the output register.
module led_grayscale_frame_store_top #(
   parameter int BOARDS = lgfs_pkg::BOARDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lgfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lgfs_pkg::rsp_type rsp_data
);

   localparam int CHAIN_LEN = BOARDS * lgfs_pkg::CHANNELS_PER_BOARD;
   localparam int CNT_W     = $clog2(CHAIN_LEN);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(CHAIN_LEN - 1);
   localparam logic [lgfs_pkg::CHAN_BITS:0] CHAIN_LIMIT =
      (lgfs_pkg::CHAN_BITS + 1)'(CHAIN_LEN);
   localparam logic [lgfs_pkg::CHAN_BITS-1:0] LAST_CHANNEL =
      lgfs_pkg::CHAN_BITS'(CHAIN_LEN - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   state_type                      state_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               target_ff;
   logic [lgfs_pkg::WORD_BITS-1:0] read_word_ff;
   logic                           bad_ff;
   lgfs_pkg::rsp_type              rsp_ff;
   logic                           rsp_valid_ff;

   logic                           out_free;
   logic                           rsp_load;
   logic                           in_chain;
   logic                           shift_en;
   lgfs_pkg::wr_type               wr;
   logic [lgfs_pkg::WORD_BITS-1:0] head;
   logic [CNT_W-1:0]               target_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = ((state_ff == ST_COMMIT) || (state_ff == ST_REPLY)) && out_free;
   assign in_chain  = ({1'b0, req_data.channel} < CHAIN_LIMIT);
   assign target_in = CNT_W'(LAST_CHANNEL - req_data.channel);
   assign shift_en  = (state_ff == ST_READ) || ((state_ff == ST_COMMIT) && out_free);

   always_comb begin
      wr.en      = req_valid && req_ready && (req_data.action == lgfs_pkg::ACTION_SET)
                   && in_chain;
      wr.channel = req_data.channel;
      wr.word    = (req_data.level > lgfs_pkg::LEVEL_MAX) ? lgfs_pkg::WORD_MAX
                                                          : req_data.level[11:0];
   end

   lgfs_chain #(
      .CHAIN_LEN(CHAIN_LEN)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .wr       (wr),
      .head     (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  priority if (req_data.action == lgfs_pkg::ACTION_READ) begin
                     count_ff  <= '0;
                     target_ff <= target_in;
                     if (in_chain) begin
                        bad_ff   <= 1'b0;
                        state_ff <= ST_READ;
                     end else begin
                        bad_ff       <= 1'b1;
                        read_word_ff <= '0;
                        state_ff     <= ST_REPLY;
                     end
                  end else if (req_data.action == lgfs_pkg::ACTION_COMMIT) begin
                     count_ff <= '0;
                     state_ff <= ST_COMMIT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_READ: begin
               if (count_ff == target_ff) begin
                  read_word_ff <= head;
               end
               if (count_ff == LAST_COUNT) begin
                  count_ff <= '0;
                  state_ff <= ST_REPLY;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_COMMIT: begin
               if (out_free) begin
                  rsp_ff.kind        <= lgfs_pkg::KIND_FRAME;
                  rsp_ff.word        <= head;
                  rsp_ff.bad_channel <= 1'b0;
                  rsp_ff.last        <= (count_ff == LAST_COUNT);
                  if (count_ff == LAST_COUNT) begin
                     count_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            ST_REPLY: begin
               if (out_free) begin
                  rsp_ff.kind        <= lgfs_pkg::KIND_READ;
                  rsp_ff.word        <= read_word_ff;
                  rsp_ff.bad_channel <= bad_ff;
                  rsp_ff.last        <= 1'b0;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // ring must be back at rest alignment whenever new words are taken
   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff == '0))
      else $error("ring count not at rest while idle");

   a_no_shift_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) || (state_ff == ST_REPLY)) |-> !shift_en)
      else $error("ring shifted outside a read or commit");

   a_bad_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_channel) |->
         ((rsp_data.word == '0) && (rsp_data.kind == lgfs_pkg::KIND_READ) && !rsp_data.last))
      else $error("bad channel reply malformed");

   a_last_ends_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && out_free && count_ff == LAST_COUNT) |=>
         (state_ff == ST_IDLE && rsp_valid && rsp_data.last))
      else $error("commit did not end on the last word");
`endif

endmodule

FILE: hdl/lgfs_cell.sv
`timescale 1ns / 1ps

module lgfs_cell #(
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             shift_en,
   input  logic [lgfs_pkg::WORD_BITS-1:0]   shift_in,
   input  lgfs_pkg::wr_type                 wr,
   output logic [lgfs_pkg::WORD_BITS-1:0]   word
);

   logic [lgfs_pkg::WORD_BITS-1:0] data_ff;
   logic [lgfs_pkg::WORD_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = shift_in;
      end else if (wr.en && (wr.channel == lgfs_pkg::CHAN_BITS'(INDEX))) begin
         data_in = wr.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign word = data_ff;

endmodule

FILE: hdl/lgfs_chain.sv
`timescale 1ns / 1ps

module lgfs_chain #(
   parameter int CHAIN_LEN = lgfs_pkg::BOARDS_DEFAULT * lgfs_pkg::CHANNELS_PER_BOARD
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             shift_en,
   input  lgfs_pkg::wr_type                 wr,
   output logic [lgfs_pkg::WORD_BITS-1:0]   head
);

   logic [lgfs_pkg::WORD_BITS-1:0] words [CHAIN_LEN];

   // ring: each cell takes its lower neighbor, cell 0 takes the head
   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      lgfs_cell #(
         .INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in ((i == 0) ? words[CHAIN_LEN-1] : words[(i == 0) ? 0 : i-1]),
         .wr       (wr),
         .word     (words[i])
      );
   end

   assign head = words[CHAIN_LEN-1];

endmodule

FILE: dv/led_grayscale_frame_store_top_tb.sv
`timescale 1ns / 1ps

module led_grayscale_frame_store_top_tb;

   localparam int CHAIN_LEN = lgfs_pkg::BOARDS_DEFAULT * lgfs_pkg::CHANNELS_PER_BOARD;
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   class frame_store_scoreboard;
      logic [lgfs_pkg::WORD_BITS-1:0] levels [CHAIN_LEN];
      lgfs_pkg::rsp_type expected_words [$];
      int mismatches;

      function new();
         foreach (levels[i]) levels[i] = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
         mismatches++;
      endtask

      task note_request(lgfs_pkg::req_type r);
         lgfs_pkg::rsp_type w;
         w = '0;
         case (r.action)
            lgfs_pkg::ACTION_SET: begin
               if (r.channel < CHAIN_LEN)
                  levels[r.channel] = (r.level > lgfs_pkg::LEVEL_MAX) ? lgfs_pkg::WORD_MAX
                                      : r.level[lgfs_pkg::WORD_BITS-1:0];
            end
            lgfs_pkg::ACTION_READ: begin
               w.kind = lgfs_pkg::KIND_READ;
               if (r.channel < CHAIN_LEN) begin
                  w.word = levels[r.channel];
               end else begin
                  w.bad_channel = 1'b1;
               end
               expected_words.push_back(w);
            end
            lgfs_pkg::ACTION_COMMIT: begin
               for (int ch = CHAIN_LEN - 1; ch >= 0; ch--) begin
                  w.kind = lgfs_pkg::KIND_FRAME;
                  w.word = levels[ch];
                  w.bad_channel = 1'b0;
                  w.last = (ch == 0);
                  expected_words.push_back(w);
               end
            end
            default: ;
         endcase
      endtask

      task check_word(lgfs_pkg::rsp_type got);
         lgfs_pkg::rsp_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", int'(got), 0);
         end else begin
            want = expected_words.pop_front();
            if (got.kind !== want.kind)
               report_mismatch("kind", int'(got.kind), int'(want.kind));
            if (got.word !== want.word)
               report_mismatch("word", int'(got.word), int'(want.word));
            if (got.bad_channel !== want.bad_channel)
               report_mismatch("bad_channel", int'(got.bad_channel),
                               int'(want.bad_channel));
            if (got.last !== want.last)
               report_mismatch("last", int'(got.last), int'(want.last));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   lgfs_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   lgfs_pkg::rsp_type rsp_data;

   int send_idle;
   int recv_idle;

   frame_store_scoreboard sb = new();

   led_grayscale_frame_store_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_data);
      end
   end

   task send_word(logic [1:0] action, logic [lgfs_pkg::CHAN_BITS-1:0] channel,
                  logic [lgfs_pkg::LEVEL_BITS-1:0] level);
      lgfs_pkg::req_type r;
      r.action  = action;
      r.channel = channel;
      r.level   = level;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task send_random(int count);
      int pick;
      logic [1:0] action;
      logic [lgfs_pkg::CHAN_BITS-1:0] channel;
      logic [lgfs_pkg::LEVEL_BITS-1:0] level;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 48)      action = lgfs_pkg::ACTION_SET;
         else if (pick < 83) action = lgfs_pkg::ACTION_READ;
         else if (pick < 91) action = lgfs_pkg::ACTION_COMMIT;
         else                action = ACTION_UNUSED;
         channel = ($urandom_range(9) == 0)
                   ? lgfs_pkg::CHAN_BITS'($urandom_range(63, CHAIN_LEN))
                   : lgfs_pkg::CHAN_BITS'($urandom_range(CHAIN_LEN - 1));
         case ($urandom_range(3))
            0: level = lgfs_pkg::LEVEL_BITS'($urandom_range(16'hFFFF));
            1: level = lgfs_pkg::LEVEL_BITS'($urandom_range(lgfs_pkg::LEVEL_MAX));
            2: level = lgfs_pkg::LEVEL_BITS'(lgfs_pkg::LEVEL_MAX + $urandom_range(1));
            default: level = lgfs_pkg::LEVEL_BITS'($urandom_range(16'hFFFF,
                                                   lgfs_pkg::LEVEL_MAX + 1));
         endcase
         send_word(action, channel, level);
      end
   endtask

   task drain();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      send_idle = 18;
      recv_idle = 63;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, saturation, outside the chain, unused code
      send_word(lgfs_pkg::ACTION_READ,   6'd0,  16'h0000);
      send_word(lgfs_pkg::ACTION_COMMIT, 6'd0,  16'h0000);
      send_word(lgfs_pkg::ACTION_SET,    6'd47, 16'hFFFF);
      send_word(lgfs_pkg::ACTION_SET,    6'd0,  16'h0000);
      send_word(lgfs_pkg::ACTION_SET,    6'd1,  16'h0FFF);
      send_word(lgfs_pkg::ACTION_SET,    6'd2,  16'h1000);
      send_word(lgfs_pkg::ACTION_SET,    6'd3,  16'h0ABC);
      send_word(lgfs_pkg::ACTION_SET,    6'd23, 16'h0555);
      send_word(lgfs_pkg::ACTION_SET,    6'd24, 16'h0AAA);
      send_word(lgfs_pkg::ACTION_SET,    6'd48, 16'h0123);
      send_word(lgfs_pkg::ACTION_SET,    6'd63, 16'hFFFF);
      send_word(lgfs_pkg::ACTION_READ,   6'd47, 16'h0000);
      send_word(lgfs_pkg::ACTION_READ,   6'd1,  16'hFFFF);
      send_word(lgfs_pkg::ACTION_READ,   6'd2,  16'h0000);
      send_word(lgfs_pkg::ACTION_READ,   6'd3,  16'h0000);
      send_word(lgfs_pkg::ACTION_READ,   6'd48, 16'h0000);
      send_word(lgfs_pkg::ACTION_READ,   6'd63, 16'hFFFF);
      send_word(ACTION_UNUSED,           6'd5,  16'hFFFF);
      send_word(ACTION_UNUSED,           6'd63, 16'h0000);
      send_word(lgfs_pkg::ACTION_READ,   6'd5,  16'h0000);
      send_word(lgfs_pkg::ACTION_COMMIT, 6'd63, 16'hFFFF);
      send_word(lgfs_pkg::ACTION_SET,    6'd0,  16'h8001);
      send_word(lgfs_pkg::ACTION_READ,   6'd0,  16'h0000);
      send_word(lgfs_pkg::ACTION_COMMIT, 6'd17, 16'h1234);

      send_random(69);
      req_valid <= 1'b0;
      drain();

      send_idle = 63;
      recv_idle = 18;
      send_random(69);
      req_valid <= 1'b0;
      drain();

      send_idle = 0;
      recv_idle = 0;
      send_random(68);
      req_valid <= 1'b0;
      drain();
      repeat (CHAIN_LEN + 8) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
